### hw/rtl/lruwb_pkg.sv
// Package with the shared types and constants of the LRU write-back cache.
`timescale 1ns / 1ps
package lruwb_pkg;
	localparam int NUM_SETS = 256;
	localparam int NUM_WAYS = 8;
	localparam int SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int MAX_SB = $clog2(NUM_SETS + 1) - 1;
	localparam logic [3:0] RANK_MAX = 4'd15;
	localparam int QDEPTH = 2;

	localparam logic [1:0] REG_SET_BITS = 2'd0;
	localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
	localparam logic [1:0] REG_WAYS = 2'd2;

	typedef struct packed {
		logic [SET_W-1:0] set;
		logic [63:0] tag;
		logic [31:0] bytes;
		logic [4:0] ways;
		logic wr;
	} req_t;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction
endpackage

### hw/rtl/lru_write_back_cache_model.sv
// Top level of the set-associative LRU write-back cache model.
`timescale 1ns / 1ps
// Usage: pulse start with address and is_store while busy is low; the word is
// taken at that edge into a two-entry queue. The back end pops one word,
// reads the whole set (all ways) from the tag and state arrays, compares the
// ways in parallel and writes the set back in the next cycle. The back end
// takes a new word only after it has written the last one back. The result
// appears on the output ports for one cycle with valid high; the receiver
// cannot stall, so results are never held.
// Configuration is written through cfg_we, cfg_index and cfg_data while the
// block is idle. After reset the state array is cleared by a pass over all
// NUM_SETS sets (256); words queue meanwhile but busy rises once the queue
// is full. Counters saturate at all ones.
module lru_write_back_cache_model import lruwb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [63:0] address,
	input logic is_store,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [4:0] cfg_data,
	output logic valid,
	output logic hit,
	output logic mru_hit,
	output logic evicted,
	output logic evicted_dirty,
	output logic [31:0] total_hits,
	output logic [31:0] total_misses,
	output logic [31:0] total_evictions,
	output logic [31:0] dirty_bytes_evicted,
	output logic [31:0] dirty_bytes_resident,
	output logic [31:0] total_mru_hits
);
	logic [3:0] set_bits_q;
	logic [4:0] block_bits_q;
	logic [3:0] ways_q;
	logic pop, q_valid;
	req_t q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q <= 4'd0;
			block_bits_q <= 5'd4;
			ways_q <= 4'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SET_BITS: set_bits_q <= cfg_data[3:0];
				REG_BLOCK_BITS: block_bits_q <= cfg_data;
				REG_WAYS: ways_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	lruwb_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .address(address),
		.is_store(is_store), .set_bits(set_bits_q), .block_bits(block_bits_q),
		.ways_in_use(ways_q), .pop(pop), .busy(busy), .q_valid(q_valid),
		.q_head(q_head)
	);

	lruwb_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_head(q_head),
		.pop(pop), .done(valid), .hit(hit), .mru_hit(mru_hit),
		.evicted(evicted), .evicted_dirty(evicted_dirty),
		.total_hits(total_hits), .total_misses(total_misses),
		.total_evictions(total_evictions),
		.dirty_bytes_evicted(dirty_bytes_evicted),
		.dirty_bytes_resident(dirty_bytes_resident),
		.total_mru_hits(total_mru_hits)
	);
endmodule

### hw/rtl/lruwb_front.sv
// Front end: takes a word, splits the address into set and tag, and queues it.
`timescale 1ns / 1ps
module lruwb_front import lruwb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [63:0] address,
	input logic is_store,
	input logic [3:0] set_bits,
	input logic [4:0] block_bits,
	input logic [3:0] ways_in_use,
	input logic pop,
	output logic busy,
	output logic q_valid,
	output req_t q_head
);
	req_t q_mem_q [QDEPTH];
	logic [1:0] cnt_q;
	logic rd_q, wr_q;
	logic [3:0] sb;
	logic [4:0] ways;
	logic [63:0] sh;
	logic [SET_W:0] smask;
	req_t nreq;
	logic push;

	always_comb begin
		sb = (set_bits > 4'(MAX_SB)) ? 4'(MAX_SB) : set_bits;
		ways = (ways_in_use == 4'd0) ? 5'd1 :
			((5'(ways_in_use) > 5'(NUM_WAYS)) ? 5'(NUM_WAYS) : 5'(ways_in_use));
		sh = address >> block_bits;
		smask = (SET_W + 1)'((1 << sb) - 1);
		nreq.set = sh[SET_W-1:0] & smask[SET_W-1:0];
		nreq.tag = sh >> sb;
		nreq.bytes = 32'd1 << block_bits;
		nreq.ways = ways;
		nreq.wr = is_store;
	end

	assign busy = (cnt_q == 2'(QDEPTH));
	assign push = start && !busy;
	assign q_valid = (cnt_q != 2'd0);
	assign q_head = q_mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) q_mem_q[wr_q] <= nreq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> q_valid)
		else $error("Pop from an empty queue.");
	assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 2'(QDEPTH))
		else $error("Queue count out of range.");
	assert property (@(posedge clk) disable iff (!arst_n) (busy && !pop) |=> busy)
		else $error("Queue changed while full and not popped.");
endmodule

### hw/rtl/lruwb_back.sv
// Back end: set lookup, LRU update, write-back accounting and counters.
`timescale 1ns / 1ps
module lruwb_back import lruwb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic q_valid,
	input req_t q_head,
	output logic pop,
	output logic done,
	output logic hit,
	output logic mru_hit,
	output logic evicted,
	output logic evicted_dirty,
	output logic [31:0] total_hits,
	output logic [31:0] total_misses,
	output logic [31:0] total_evictions,
	output logic [31:0] dirty_bytes_evicted,
	output logic [31:0] dirty_bytes_resident,
	output logic [31:0] total_mru_hits
);
	typedef struct packed {
		logic v;
		logic d;
		logic [3:0] r;
	} meta_t;
	typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LOOK} state_t;

	meta_t meta_mem [NUM_SETS][NUM_WAYS];
	logic [63:0] tag_mem [NUM_SETS][NUM_WAYS];
	meta_t rm_q [NUM_WAYS];
	logic [63:0] rt_q [NUM_WAYS];
	state_t state_q;
	logic [SET_W:0] clr_q;
	req_t req_q;
	meta_t nm [NUM_WAYS];
	logic wtag;
	logic [WAY_W-1:0] tgt;
	logic h, dr, ev, evd;
	logic [31:0] hits_n, miss_n, evc_n, dbe_n, dbr_n, dref_n;

	always_comb begin
		logic found, ffound, act;
		logic [WAY_W-1:0] hw, fw, mw, vw;
		logic [4:0] best;
		logic [3:0] worst, lim;
		found = 1'b0; ffound = 1'b0; hw = '0; fw = '0; mw = '0; vw = '0;
		best = 5'd31; worst = '0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			act = (5'(w) < req_q.ways);
			if (act && !found && rm_q[w].v && rt_q[w] == req_q.tag) begin
				found = 1'b1; hw = WAY_W'(w);
			end
			if (act && !ffound && !rm_q[w].v) begin
				ffound = 1'b1; fw = WAY_W'(w);
			end
			if (act && rm_q[w].v && 5'(rm_q[w].r) < best) begin
				best = 5'(rm_q[w].r); mw = WAY_W'(w);
			end
			if (act && (w == 0 || rm_q[w].r > worst)) begin
				worst = rm_q[w].r; vw = WAY_W'(w);
			end
		end
		h = found;
		dr = found && (mw == hw);
		ev = !found && !ffound;
		evd = ev && rm_q[vw].d;
		tgt = found ? hw : (ffound ? fw : vw);
		wtag = !found;
		lim = (!found && ffound) ? RANK_MAX : rm_q[tgt].r;
		hits_n = total_hits; miss_n = total_misses; evc_n = total_evictions;
		dbe_n = dirty_bytes_evicted; dbr_n = dirty_bytes_resident;
		dref_n = total_mru_hits;
		if (found) begin
			hits_n = sat_add(total_hits, 32'd1);
			if (dr) dref_n = sat_add(total_mru_hits, 32'd1);
			if (req_q.wr && !rm_q[hw].d) dbr_n = sat_add(dirty_bytes_resident, req_q.bytes);
		end else begin
			miss_n = sat_add(total_misses, 32'd1);
			if (ev) begin
				evc_n = sat_add(total_evictions, 32'd1);
				if (evd) begin
					dbe_n = sat_add(dirty_bytes_evicted, req_q.bytes);
					if (!req_q.wr)
						dbr_n = (dirty_bytes_resident > req_q.bytes) ?
							dirty_bytes_resident - req_q.bytes : 32'd0;
				end else if (req_q.wr) begin
					dbr_n = sat_add(dirty_bytes_resident, req_q.bytes);
				end
			end else if (req_q.wr) begin
				dbr_n = sat_add(dirty_bytes_resident, req_q.bytes);
			end
		end
		for (int w = 0; w < NUM_WAYS; w++) begin
			nm[w] = rm_q[w];
			act = (5'(w) < req_q.ways);
			if (WAY_W'(w) == tgt) begin
				nm[w].r = '0;
				nm[w].v = 1'b1;
				if (found) nm[w].d = rm_q[w].d | req_q.wr;
				else if (ffound) nm[w].d = req_q.wr;
				else nm[w].d = evd ? req_q.wr : (rm_q[w].d | req_q.wr);
			end else if (act && rm_q[w].v && (rm_q[w].r < lim || (!found && ffound))
					&& rm_q[w].r < RANK_MAX) begin
				nm[w].r = rm_q[w].r + 4'd1;
			end
		end
	end

	assign pop = (state_q == S_IDLE) && q_valid;

	always_ff @(posedge clk) begin
		if (state_q == S_CLEAR) begin
			for (int w = 0; w < NUM_WAYS; w++) meta_mem[clr_q[SET_W-1:0]][w] <= '0;
		end else if (state_q == S_LOOK) begin
			for (int w = 0; w < NUM_WAYS; w++) meta_mem[req_q.set][w] <= nm[w];
			if (wtag) tag_mem[req_q.set][tgt] <= req_q.tag;
		end
		if (pop) begin
			req_q <= q_head;
			for (int w = 0; w < NUM_WAYS; w++) begin
				rm_q[w] <= meta_mem[q_head.set][w];
				rt_q[w] <= tag_mem[q_head.set][w];
			end
		end
		if (state_q == S_LOOK) begin
			hit <= h;
			mru_hit <= dr;
			evicted <= ev;
			evicted_dirty <= evd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			done <= 1'b0;
			total_hits <= '0;
			total_misses <= '0;
			total_evictions <= '0;
			dirty_bytes_evicted <= '0;
			dirty_bytes_resident <= '0;
			total_mru_hits <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (SET_W + 1)'(NUM_SETS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (q_valid) state_q <= S_LOOK;
				S_LOOK: begin
					state_q <= S_IDLE;
					done <= 1'b1;
					total_hits <= hits_n;
					total_misses <= miss_n;
					total_evictions <= evc_n;
					dirty_bytes_evicted <= dbe_n;
					dirty_bytes_resident <= dbr_n;
					total_mru_hits <= dref_n;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) done |-> $past(state_q) == S_LOOK)
		else $error("Result without a lookup.");
	assert property (@(posedge clk) disable iff (!arst_n) pop |=> state_q == S_LOOK)
		else $error("Popped word was not looked up.");
	assert property (@(posedge clk) disable iff (!arst_n) (state_q == S_CLEAR) |-> !pop)
		else $error("Pop during the clearing pass.");
endmodule
